// ===== rtl/core/rpcd_pkg.sv =====
// Shared types, constants and helper functions for the rod pair closest distance block.
package rpcd_pkg;

  localparam int COORD_W  = 32;
  localparam int AXIS_W   = 32;
  localparam int LEN_W    = 31;
  localparam int DIST_W   = 48;
  localparam int PARAM_W  = 32;
  localparam int RU_W     = 33;
  localparam int C_W      = 32;
  localparam int CC_W     = 61;
  localparam int NUM_W    = 35;
  localparam int QUO_W    = 62;
  localparam int REM_W    = 61;
  localparam int DIV_STEPS = QUO_W;
  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = 2;
  localparam int WIDE_W   = 66;

  localparam logic [31:0] TOL_RESET = 32'd4295;
  localparam logic signed [WIDE_W-1:0] RU_MAX  = 66'sh0_FFFF_FFFF;
  localparam logic signed [WIDE_W-1:0] ONE_Q30 = 66'sh4000_0000;
  localparam logic signed [WIDE_W-1:0] DIST_MAX = 66'sh0_FFFF_FFFF_FFFF;
  localparam logic [63:0] ONE_Q60 = 64'h1000_0000_0000_0000;

  typedef struct packed {
    logic signed [COORD_W-1:0] rel_x;
    logic signed [COORD_W-1:0] rel_y;
    logic signed [COORD_W-1:0] rel_z;
    logic signed [AXIS_W-1:0]  axis_a_x;
    logic signed [AXIS_W-1:0]  axis_a_y;
    logic signed [AXIS_W-1:0]  axis_a_z;
    logic signed [AXIS_W-1:0]  axis_b_x;
    logic signed [AXIS_W-1:0]  axis_b_y;
    logic signed [AXIS_W-1:0]  axis_b_z;
    logic [LEN_W-1:0]          half_len_a;
    logic [LEN_W-1:0]          half_len_b;
  } rpcd_in_t;

  typedef struct packed {
    logic [DIST_W-1:0]         dist_sq;
    logic signed [PARAM_W-1:0] param_a;
    logic signed [PARAM_W-1:0] param_b;
  } rpcd_out_t;

  // Classified request handed from the front end to the back end.
  typedef struct packed {
    logic signed [NUM_W-1:0] num_a;
    logic signed [NUM_W-1:0] num_b;
    logic [CC_W-1:0]         cc;
    logic signed [C_W-1:0]   c;
    logic signed [RU_W-1:0]  ru1;
    logic signed [RU_W-1:0]  ru2;
    logic [DIST_W-1:0]       rr16;
    logic [LEN_W-1:0]        lh1;
    logic [LEN_W-1:0]        lh2;
    logic                    par;
    logic                    zero;
  } rpcd_job_t;

  // One stage of the shared-denominator divider pipeline.
  typedef struct packed {
    logic [REM_W-1:0]        rem_a;
    logic [REM_W-1:0]        rem_b;
    logic [QUO_W-1:0]        q_a;
    logic [QUO_W-1:0]        q_b;
    logic [1:0]              nlo_a;
    logic [1:0]              nlo_b;
    logic                    neg_a;
    logic                    neg_b;
    logic                    sat_a;
    logic                    sat_b;
    logic [CC_W-1:0]         den;
    logic signed [C_W-1:0]   c;
    logic signed [RU_W-1:0]  ru1;
    logic signed [RU_W-1:0]  ru2;
    logic [DIST_W-1:0]       rr16;
    logic [LEN_W-1:0]        lh1;
    logic [LEN_W-1:0]        lh2;
    logic                    par;
    logic                    zero;
  } rpcd_div_t;

  // Signed division by 2^k with truncation toward zero.
  function automatic logic signed [WIDE_W-1:0] trunc_shr(input logic signed [WIDE_W-1:0] x,
                                                         input int unsigned k);
    logic signed [WIDE_W-1:0] bias;
    bias = x[WIDE_W-1] ? ((66'sd1 <<< k) - 66'sd1) : 66'sd0;
    return (x + bias) >>> k;
  endfunction

  function automatic logic signed [WIDE_W-1:0] sat_mag(input logic signed [WIDE_W-1:0] x,
                                                       input logic signed [WIDE_W-1:0] lim);
    logic signed [WIDE_W-1:0] res;
    res = x;
    if (x > lim) begin
      res = lim;
    end else if (x < -lim) begin
      res = -lim;
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/rpcd_front.sv =====
// Front end: accepts requests, forms projections and cosine, classifies the rod pair.
module rpcd_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  rpcd_pkg::rpcd_in_t   in_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [31:0]          cfg_data,
  input  logic                 q_full,
  output logic                 push,
  output rpcd_pkg::rpcd_job_t  push_item
);

  localparam int PW = rpcd_pkg::COORD_W + rpcd_pkg::AXIS_W;
  localparam int SW = 2 * rpcd_pkg::COORD_W;

  logic adv;
  logic [3:0] v_r;
  logic [31:0] tol_r;

  logic signed [rpcd_pkg::COORD_W-1:0] rv [3];
  logic signed [rpcd_pkg::AXIS_W-1:0]  av [3];
  logic signed [rpcd_pkg::AXIS_W-1:0]  bv [3];

  logic signed [PW-1:0] pra_r [3];
  logic signed [PW-1:0] prb_r [3];
  logic signed [2*rpcd_pkg::AXIS_W-1:0] pab_r [3];
  logic signed [SW-1:0] rsq_r [3];
  logic [rpcd_pkg::LEN_W-1:0] lh1_1_r, lh2_1_r;

  logic signed [rpcd_pkg::WIDE_W-1:0] ru1_nxt, ru2_nxt, c_nxt;
  logic [SW+1:0] rr_nxt;
  logic signed [rpcd_pkg::RU_W-1:0] ru1_2_r, ru2_2_r;
  logic signed [rpcd_pkg::C_W-1:0] c_2_r;
  logic [rpcd_pkg::DIST_W-1:0] rr16_2_r;
  logic [rpcd_pkg::LEN_W-1:0] lh1_2_r, lh2_2_r;

  logic signed [63:0] ccp_r;
  logic signed [64:0] cru1_r, cru2_r;
  logic signed [rpcd_pkg::RU_W-1:0] ru1_3_r, ru2_3_r;
  logic signed [rpcd_pkg::C_W-1:0] c_3_r;
  logic [rpcd_pkg::DIST_W-1:0] rr16_3_r;
  logic [rpcd_pkg::LEN_W-1:0] lh1_3_r, lh2_3_r;

  rpcd_pkg::rpcd_job_t job_nxt, job_r;

  assign adv       = !(v_r[3] && q_full);
  assign in_stall  = !adv;
  assign push      = v_r[3] && adv;
  assign push_item = job_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= rpcd_pkg::TOL_RESET;
    end else if (cfg_valid) begin
      tol_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[2:0], in_valid};
    end
  end

  always_comb begin
    rv[0] = in_data.rel_x;
    rv[1] = in_data.rel_y;
    rv[2] = in_data.rel_z;
    av[0] = in_data.axis_a_x;
    av[1] = in_data.axis_a_y;
    av[2] = in_data.axis_a_z;
    bv[0] = in_data.axis_b_x;
    bv[1] = in_data.axis_b_y;
    bv[2] = in_data.axis_b_z;
  end

  // Stage 1: all nine dot product terms and the squared components.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        pra_r[i] <= rv[i] * av[i];
        prb_r[i] <= rv[i] * bv[i];
        pab_r[i] <= av[i] * bv[i];
        rsq_r[i] <= rv[i] * rv[i];
      end
      lh1_1_r <= in_data.half_len_a;
      lh2_1_r <= in_data.half_len_b;
    end
  end

  // Stage 2: dot product terms are rescaled, summed and saturated; squares are summed.
  always_comb begin
    ru1_nxt = '0;
    ru2_nxt = '0;
    c_nxt   = '0;
    rr_nxt  = '0;
    for (int i = 0; i < 3; i++) begin
      ru1_nxt = ru1_nxt + rpcd_pkg::trunc_shr(rpcd_pkg::WIDE_W'(pra_r[i]), 30);
      ru2_nxt = ru2_nxt + rpcd_pkg::trunc_shr(rpcd_pkg::WIDE_W'(prb_r[i]), 30);
      c_nxt   = c_nxt + rpcd_pkg::trunc_shr(rpcd_pkg::WIDE_W'(pab_r[i]), 30);
      rr_nxt  = rr_nxt + (SW+2)'($unsigned(rsq_r[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ru1_2_r  <= rpcd_pkg::RU_W'(rpcd_pkg::sat_mag(ru1_nxt, rpcd_pkg::RU_MAX));
      ru2_2_r  <= rpcd_pkg::RU_W'(rpcd_pkg::sat_mag(ru2_nxt, rpcd_pkg::RU_MAX));
      c_2_r    <= rpcd_pkg::C_W'(rpcd_pkg::sat_mag(c_nxt, rpcd_pkg::ONE_Q30));
      rr16_2_r <= rr_nxt[16 +: rpcd_pkg::DIST_W];
      lh1_2_r  <= lh1_1_r;
      lh2_2_r  <= lh2_1_r;
    end
  end

  // Stage 3: cosine products.
  always_ff @(posedge clk) begin
    if (adv) begin
      ccp_r    <= c_2_r * c_2_r;
      cru1_r   <= c_2_r * ru1_2_r;
      cru2_r   <= c_2_r * ru2_2_r;
      ru1_3_r  <= ru1_2_r;
      ru2_3_r  <= ru2_2_r;
      c_3_r    <= c_2_r;
      rr16_3_r <= rr16_2_r;
      lh1_3_r  <= lh1_2_r;
      lh2_3_r  <= lh2_2_r;
    end
  end

  // Stage 4: denominator, numerators and the parallel decision.
  always_comb begin
    job_nxt.cc    = rpcd_pkg::CC_W'(rpcd_pkg::ONE_Q60 - $unsigned(ccp_r));
    job_nxt.num_a = rpcd_pkg::NUM_W'(rpcd_pkg::WIDE_W'(ru1_3_r)
                    - rpcd_pkg::trunc_shr(rpcd_pkg::WIDE_W'(cru2_r), 30));
    job_nxt.num_b = rpcd_pkg::NUM_W'(rpcd_pkg::trunc_shr(rpcd_pkg::WIDE_W'(cru1_r), 30)
                    - rpcd_pkg::WIDE_W'(ru2_3_r));
    job_nxt.c     = c_3_r;
    job_nxt.ru1   = ru1_3_r;
    job_nxt.ru2   = ru2_3_r;
    job_nxt.rr16  = rr16_3_r;
    job_nxt.lh1   = lh1_3_r;
    job_nxt.lh2   = lh2_3_r;
    // Exactly parallel axes take the parallel path even with a zero tolerance.
    job_nxt.par   = (job_nxt.cc == '0) || (job_nxt.cc < {1'b0, tol_r, 28'd0});
    job_nxt.zero  = job_nxt.par && ((ru1_3_r == '0) || (ru2_3_r == '0));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      job_r <= job_nxt;
    end
  end

endmodule

// ===== rtl/core/rpcd_queue.sv =====
// Short request queue between the front end and the back end.
module rpcd_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  rpcd_pkg::rpcd_job_t  push_item,
  output logic                 full,
  input  logic                 take,
  output logic                 out_valid,
  output rpcd_pkg::rpcd_job_t  out_item
);

  rpcd_pkg::rpcd_job_t mem_r [rpcd_pkg::QDEPTH];
  logic [rpcd_pkg::QPTR_W-1:0] wr_r, rd_r;
  logic [rpcd_pkg::QPTR_W:0] count_r;
  logic pop;

  assign full      = (count_r == (rpcd_pkg::QPTR_W+1)'(rpcd_pkg::QDEPTH));
  assign out_valid = (count_r != '0);
  assign pop       = out_valid && take;
  assign out_item  = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
      count_r <= count_r + (rpcd_pkg::QPTR_W+1)'(push) - (rpcd_pkg::QPTR_W+1)'(pop);
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("queue written while full");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count did not follow a lone push");
  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    ((count_r == '0) || full) |-> (wr_r == rd_r))
    else $error("queue pointers disagree with count");
`endif

endmodule

// ===== rtl/core/rpcd_div.sv =====
// Back end divider: pipelined radix-2 division of both numerators by 1 - c^2.
module rpcd_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 in_valid,
  input  rpcd_pkg::rpcd_job_t  in_item,
  output logic                 out_valid,
  output rpcd_pkg::rpcd_div_t  out_item
);

  localparam int NS = rpcd_pkg::DIV_STEPS;

  rpcd_pkg::rpcd_div_t st_r [0:NS];
  rpcd_pkg::rpcd_div_t pre_nxt;
  logic [NS:0] v_r;
  logic [rpcd_pkg::NUM_W-1:0] na, nb;

  assign out_valid = v_r[NS];
  assign out_item  = st_r[NS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[NS-1:0], in_valid};
    end
  end

  // A quotient of 2^62 or more is detected up front as n >= 4 * den.
  always_comb begin
    na = in_item.num_a[rpcd_pkg::NUM_W-1] ? rpcd_pkg::NUM_W'(-in_item.num_a) : in_item.num_a;
    nb = in_item.num_b[rpcd_pkg::NUM_W-1] ? rpcd_pkg::NUM_W'(-in_item.num_b) : in_item.num_b;
    pre_nxt.rem_a = rpcd_pkg::REM_W'(na >> 2);
    pre_nxt.rem_b = rpcd_pkg::REM_W'(nb >> 2);
    pre_nxt.q_a   = '0;
    pre_nxt.q_b   = '0;
    pre_nxt.nlo_a = na[1:0];
    pre_nxt.nlo_b = nb[1:0];
    pre_nxt.neg_a = in_item.num_a[rpcd_pkg::NUM_W-1];
    pre_nxt.neg_b = in_item.num_b[rpcd_pkg::NUM_W-1];
    pre_nxt.sat_a = (rpcd_pkg::CC_W+2)'(na) >= {in_item.cc, 2'b00};
    pre_nxt.sat_b = (rpcd_pkg::CC_W+2)'(nb) >= {in_item.cc, 2'b00};
    pre_nxt.den   = in_item.cc;
    pre_nxt.c     = in_item.c;
    pre_nxt.ru1   = in_item.ru1;
    pre_nxt.ru2   = in_item.ru2;
    pre_nxt.rr16  = in_item.rr16;
    pre_nxt.lh1   = in_item.lh1;
    pre_nxt.lh2   = in_item.lh2;
    pre_nxt.par   = in_item.par;
    pre_nxt.zero  = in_item.zero;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r[0] <= pre_nxt;
    end
  end

  for (genvar s = 0; s < NS; s++) begin : g_step
    localparam int BITPOS = NS - 1 - s;
    logic in_a, in_b, ge_a, ge_b;
    logic [rpcd_pkg::REM_W:0] ta, tb, dd;
    rpcd_pkg::rpcd_div_t nx;

    always_comb begin
      nx   = st_r[s];
      // Only the two lowest numerator bits remain below the initial remainder.
      in_a = (BITPOS == NS - 1) ? st_r[s].nlo_a[1] :
             (BITPOS == NS - 2) ? st_r[s].nlo_a[0] : 1'b0;
      in_b = (BITPOS == NS - 1) ? st_r[s].nlo_b[1] :
             (BITPOS == NS - 2) ? st_r[s].nlo_b[0] : 1'b0;
      dd   = {1'b0, st_r[s].den};
      ta   = {st_r[s].rem_a, in_a};
      tb   = {st_r[s].rem_b, in_b};
      ge_a = (ta >= dd);
      ge_b = (tb >= dd);
      nx.rem_a = ge_a ? rpcd_pkg::REM_W'(ta - dd) : ta[rpcd_pkg::REM_W-1:0];
      nx.rem_b = ge_b ? rpcd_pkg::REM_W'(tb - dd) : tb[rpcd_pkg::REM_W-1:0];
      nx.q_a   = {st_r[s].q_a[rpcd_pkg::QUO_W-2:0], ge_a};
      nx.q_b   = {st_r[s].q_b[rpcd_pkg::QUO_W-2:0], ge_b};
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st_r[s+1] <= nx;
      end
    end
  end

endmodule

// ===== rtl/core/rpcd_finish.sv =====
// Back end finish: limits the parameters to the half lengths and forms the squared distance.
module rpcd_finish (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 in_valid,
  input  rpcd_pkg::rpcd_div_t  in_item,
  output logic                 out_valid,
  output rpcd_pkg::rpcd_out_t  out_data
);

  localparam int WW = rpcd_pkg::WIDE_W;
  localparam int PW = rpcd_pkg::PARAM_W;

  logic [6:0] v_r;

  // C1
  logic [rpcd_pkg::QUO_W-1:0] qa, qb;
  logic signed [WW-1:0] la_half, mu_half;
  logic signed [63:0] la_w, mu_w;
  logic [63:0] mag_la, mag_mu;
  logic viol_nxt, pick_a_nxt;
  logic signed [PW-1:0] lha, lhb;
  logic signed [PW-1:0] la_fix_r, mu_fix_r, la1_r, mu1_r;
  logic viol_r, pick_a_r;
  logic signed [rpcd_pkg::C_W-1:0] c1_r, c2_r, c3_r;
  logic signed [rpcd_pkg::RU_W-1:0] ru1_1_r, ru2_1_r, ru1_2_r, ru2_2_r, ru1_3_r, ru2_3_r;
  logic [rpcd_pkg::DIST_W-1:0] rr1_r, rr2_r, rr3_r, rr4_r, rr5_r, rr6_r;
  logic [rpcd_pkg::LEN_W-1:0] lh1_1_r, lh2_1_r, lh1_2_r, lh2_2_r;
  logic z1_r, z2_r, z3_r, z4_r, z5_r, z6_r;

  // C2
  logic signed [PW-1:0] fix_sel;
  logic signed [63:0] fprod_r;
  logic signed [PW-1:0] la_fix2_r, mu_fix2_r, la2_r, mu2_r;
  logic viol2_r, pick2_r;

  // C3
  logic signed [WW-1:0] t3, mn, ln, amn, aln, lim1, lim2;
  logic signed [PW-1:0] la_nxt, mu_nxt, la3_r, mu3_r;

  // E1..E4
  logic signed [63:0] sqa_r, sqm_r, lac_r;
  logic signed [64:0] mur_r, lar_r;
  logic signed [PW-1:0] la4_r, mu4_r, la5_r, mu5_r, la6_r, mu6_r;
  logic signed [WW-1:0] part_nxt, part_r, part6_r, ppm_r, d_nxt;
  logic signed [33:0] p_r;
  rpcd_pkg::rpcd_out_t out_nxt, out_r;

  assign out_valid = v_r[6];
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[5:0], in_valid};
    end
  end

  // C1: pick the unclamped parameters and decide which one is clamped first.
  always_comb begin
    qa      = in_item.sat_a ? '1 : in_item.q_a;
    qb      = in_item.sat_b ? '1 : in_item.q_b;
    la_half = rpcd_pkg::trunc_shr(WW'(in_item.ru1), 1);
    mu_half = rpcd_pkg::trunc_shr(WW'(in_item.ru2), 1);
    if (in_item.par) begin
      la_w   = 64'(la_half);
      mu_w   = -64'(mu_half);
      mag_la = 64'(la_half[WW-1] ? -la_half : la_half);
      mag_mu = 64'(mu_half[WW-1] ? -mu_half : mu_half);
    end else begin
      la_w   = in_item.neg_a ? -$signed({2'b00, qa}) : $signed({2'b00, qa});
      mu_w   = in_item.neg_b ? -$signed({2'b00, qb}) : $signed({2'b00, qb});
      mag_la = {2'b00, qa};
      mag_mu = {2'b00, qb};
    end
    viol_nxt   = (mag_la > 64'(in_item.lh1)) || (mag_mu > 64'(in_item.lh2));
    pick_a_nxt = $signed(mag_la - 64'(in_item.lh1)) > $signed(mag_mu - 64'(in_item.lh2));
    lha        = $signed({1'b0, in_item.lh1});
    lhb        = $signed({1'b0, in_item.lh2});
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      la_fix_r <= la_w[63] ? -lha : lha;
      mu_fix_r <= mu_w[63] ? -lhb : lhb;
      la1_r    <= la_w[PW-1:0];
      mu1_r    <= mu_w[PW-1:0];
      viol_r   <= viol_nxt;
      pick_a_r <= pick_a_nxt;
      c1_r     <= in_item.c;
      ru1_1_r  <= in_item.ru1;
      ru2_1_r  <= in_item.ru2;
      rr1_r    <= in_item.rr16;
      lh1_1_r  <= in_item.lh1;
      lh2_1_r  <= in_item.lh2;
      z1_r     <= in_item.zero;
    end
  end

  // C2: project the clamped parameter onto the other axis.
  assign fix_sel = pick_a_r ? la_fix_r : mu_fix_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      fprod_r   <= fix_sel * c1_r;
      la_fix2_r <= la_fix_r;
      mu_fix2_r <= mu_fix_r;
      la2_r     <= la1_r;
      mu2_r     <= mu1_r;
      viol2_r   <= viol_r;
      pick2_r   <= pick_a_r;
      c2_r      <= c1_r;
      ru1_2_r   <= ru1_1_r;
      ru2_2_r   <= ru2_1_r;
      rr2_r     <= rr1_r;
      lh1_2_r   <= lh1_1_r;
      lh2_2_r   <= lh2_1_r;
      z2_r      <= z1_r;
    end
  end

  // C3: recompute the other parameter and clamp it in turn.
  always_comb begin
    t3   = rpcd_pkg::trunc_shr(WW'(fprod_r), 30);
    mn   = t3 - WW'(ru2_2_r);
    ln   = t3 + WW'(ru1_2_r);
    amn  = mn[WW-1] ? -mn : mn;
    aln  = ln[WW-1] ? -ln : ln;
    lim1 = $signed({{(WW-rpcd_pkg::LEN_W){1'b0}}, lh1_2_r});
    lim2 = $signed({{(WW-rpcd_pkg::LEN_W){1'b0}}, lh2_2_r});
    if (!viol2_r) begin
      la_nxt = la2_r;
      mu_nxt = mu2_r;
    end else if (pick2_r) begin
      la_nxt = la_fix2_r;
      mu_nxt = (amn > lim2) ? PW'(mn[WW-1] ? -lim2 : lim2) : PW'(mn);
    end else begin
      mu_nxt = mu_fix2_r;
      la_nxt = (aln > lim1) ? PW'(ln[WW-1] ? -lim1 : lim1) : PW'(ln);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      la3_r   <= la_nxt;
      mu3_r   <= mu_nxt;
      c3_r    <= c2_r;
      ru1_3_r <= ru1_2_r;
      ru2_3_r <= ru2_2_r;
      rr3_r   <= rr2_r;
      z3_r    <= z2_r;
    end
  end

  // E1: distance products.
  always_ff @(posedge clk) begin
    if (adv) begin
      sqa_r <= la3_r * la3_r;
      sqm_r <= mu3_r * mu3_r;
      lac_r <= la3_r * c3_r;
      mur_r <= mu3_r * ru2_3_r;
      lar_r <= la3_r * ru1_3_r;
      la4_r <= la3_r;
      mu4_r <= mu3_r;
      rr4_r <= rr3_r;
      z4_r  <= z3_r;
    end
  end

  // E2: partial sum of every term except the cross term.
  always_comb begin
    part_nxt = $signed({{(WW-rpcd_pkg::DIST_W){1'b0}}, rr4_r})
             + rpcd_pkg::trunc_shr(WW'(sqa_r), 16)
             + rpcd_pkg::trunc_shr(WW'(sqm_r), 16)
             + 66'sd2 * rpcd_pkg::trunc_shr(WW'(mur_r), 16)
             - 66'sd2 * rpcd_pkg::trunc_shr(WW'(lar_r), 16);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_r    <= 34'(rpcd_pkg::trunc_shr(WW'(lac_r), 30));
      part_r <= part_nxt;
      la5_r  <= la4_r;
      mu5_r  <= mu4_r;
      rr5_r  <= rr4_r;
      z5_r   <= z4_r;
    end
  end

  // E3: cross term product.
  always_ff @(posedge clk) begin
    if (adv) begin
      ppm_r   <= p_r * mu5_r;
      part6_r <= part_r;
      la6_r   <= la5_r;
      mu6_r   <= mu5_r;
      rr6_r   <= rr5_r;
      z6_r    <= z5_r;
    end
  end

  // E4: final sum, clamp at zero, saturate high; a zero job passes rr16 with zero parameters.
  always_comb begin
    d_nxt = part6_r - 66'sd2 * rpcd_pkg::trunc_shr(ppm_r, 16);
    if (z6_r) begin
      out_nxt.dist_sq = rr6_r;
      out_nxt.param_a = '0;
      out_nxt.param_b = '0;
    end else begin
      if (d_nxt < 66'sd0) begin
        out_nxt.dist_sq = '0;
      end else if (d_nxt > rpcd_pkg::DIST_MAX) begin
        out_nxt.dist_sq = '1;
      end else begin
        out_nxt.dist_sq = d_nxt[rpcd_pkg::DIST_W-1:0];
      end
      out_nxt.param_a = la6_r;
      out_nxt.param_b = mu6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= out_nxt;
    end
  end

endmodule

// ===== rtl/core/rod_pair_closest_distance.sv =====
// Top level of the rod pair closest distance block.
// A new rod pair request can be accepted every clock cycle while in_stall is low, and one
// result leaves per cycle while out_stall is low. Four front-end stages form the
// projections, the cosine and the parallel decision, a four-entry queue follows, and the
// back end runs a 63-stage radix-2 divider shared by both parameters (an entry stage that
// detects saturation, then one quotient bit per stage), three clamping
// stages and four distance stages ending in the output register. The front end keeps
// accepting requests while a result waits, until the queue is full.
module rod_pair_closest_distance (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  rpcd_pkg::rpcd_in_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output rpcd_pkg::rpcd_out_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [31:0]          cfg_data
);

  logic q_full, push, q_valid, b_adv, div_valid;
  rpcd_pkg::rpcd_job_t push_item, q_item;
  rpcd_pkg::rpcd_div_t div_item;

  assign b_adv = !(out_valid && out_stall);

  rpcd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  rpcd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .take      (b_adv),
    .out_valid (q_valid),
    .out_item  (q_item)
  );

  rpcd_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (b_adv),
    .in_valid  (q_valid),
    .in_item   (q_item),
    .out_valid (div_valid),
    .out_item  (div_item)
  );

  rpcd_finish u_finish (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (b_adv),
    .in_valid  (div_valid),
    .in_item   (div_item),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
